// File: rtl/core/urlpd_pkg.sv
// Shared types, character codes and hex helpers for the URL percent decoder.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package urlpd_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    localparam logic [7:0] LIMIT_RESET  = 8'd63;

    // Bits per hex digit (radix 16)
    localparam int HEX_BITS = 4;

    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = $clog2(MAX_RES + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_NONE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX  = 3'b100
    } phase_t;

    // One queued request: up to three results from one source item
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [RES_CNT_W-1:0]    n;
        logic                    term;   // last result is the terminator
    } req_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              full;
        logic              empty;
    } qstat_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Letters sit at low nibble 1..6 in both cases
    function automatic logic [HEX_BITS-1:0] hex_val(input logic [7:0] c);
        return c[6] ? HEX_BITS'(c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/urlpd_front.sv
// Front end: accepts source items, tracks escape state and output count,
// and builds one request per item. Depends on urlpd_pkg.
`default_nettype none

module urlpd_front import urlpd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       accept,
    input  wire logic [7:0] src_byte,
    input  wire logic       src_end,
    output req_t            req,
    output logic            push
);

    logic [7:0] lim_reg, lim_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] fh_reg,  fh_next;
    phase_t     ph_reg,  ph_next;

    logic                 is_full, c_hex, is_pct, do_plain, go_hex;
    logic [7:0]           room, pbyte, pre0, decoded;
    logic [1:0]           avail, npre, ncand, nemit;
    logic [MAX_RES-1:0][7:0] cand;
    logic [7:0]           cnt_sum;

    assign is_full = cnt_reg >= lim_reg;
    assign room    = lim_reg - cnt_reg;
    assign avail   = is_full ? 2'd0 : ((room >= 8'd3) ? 2'd3 : room[1:0]);
    assign c_hex   = is_hex(src_byte);
    assign is_pct  = src_byte == CHAR_PERCENT;
    assign pbyte   = (src_byte == CHAR_PLUS) ? CHAR_SPACE : src_byte;
    assign decoded = {hex_val(fh_reg), hex_val(src_byte)};

    always_comb begin
        npre     = 2'd0;
        pre0     = CHAR_PERCENT;
        do_plain = 1'b0;
        go_hex   = 1'b0;
        if (src_end) begin
            unique case (ph_reg)
                PH_PCT:  npre = 2'd1;
                PH_HEX:  npre = 2'd2;
                default: npre = 2'd0;
            endcase
        end else if (!is_full) begin
            unique case (ph_reg)
                PH_PCT: begin
                    if (c_hex) begin
                        go_hex = 1'b1;
                    end else begin
                        npre     = 2'd1;
                        do_plain = 1'b1;
                    end
                end
                PH_HEX: begin
                    if (c_hex) begin
                        npre = 2'd1;
                        pre0 = decoded;
                    end else begin
                        npre     = 2'd2;
                        do_plain = 1'b1;
                    end
                end
                default: do_plain = 1'b1;
            endcase
        end
    end

    // Plain byte lands right after the prefix bytes
    assign ncand   = npre + {1'b0, do_plain && !is_pct};
    assign nemit   = (ncand < avail) ? ncand : avail;
    assign cand[0] = (npre >= 2'd1) ? pre0 : pbyte;
    assign cand[1] = (npre >= 2'd2) ? fh_reg : pbyte;
    assign cand[2] = pbyte;
    assign cnt_sum = cnt_reg + {6'd0, nemit};

    always_comb begin
        lim_next = cfg_we ? cfg_wdata : lim_reg;
        cnt_next = cnt_reg;
        fh_next  = fh_reg;
        ph_next  = ph_reg;
        if (accept) begin
            if (src_end) begin
                cnt_next = 8'd0;
                fh_next  = CHAR_NUL;
                ph_next  = PH_NONE;
            end else begin
                cnt_next = cnt_sum;
                ph_next  = PH_NONE;
                if (go_hex) begin
                    ph_next = PH_HEX;
                    fh_next = src_byte;
                end else if (do_plain && is_pct && (npre < avail)) begin
                    ph_next = PH_PCT;
                end
                if (cnt_sum >= lim_reg) ph_next = PH_NONE;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            req.bytes[i] = (RES_CNT_W'(i) < nemit) ? cand[i] : CHAR_NUL;
        end
        req.n    = nemit + {1'b0, src_end};
        req.term = src_end;
    end

    assign push = accept && (req.n != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= LIMIT_RESET;
            cnt_reg <= 8'd0;
            fh_reg  <= CHAR_NUL;
            ph_reg  <= PH_NONE;
        end else begin
            lim_reg <= lim_next;
            cnt_reg <= cnt_next;
            fh_reg  <= fh_next;
            ph_reg  <= ph_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/urlpd_queue.sv
// Short request queue between front and back ends.
// Depends on urlpd_pkg for the request type and depth.
`default_nettype none

module urlpd_queue import urlpd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire req_t wr_req,
    input  wire logic pop,
    output req_t      rd_req,
    output qstat_t    stat
);

    req_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0] lvl_reg, lvl_next;
    logic              do_push, do_pop;

    assign stat.level = lvl_reg;
    assign stat.full  = lvl_reg == QLVL_W'(QDEPTH);
    assign stat.empty = lvl_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_req     = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        lvl_next    = lvl_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) lvl_next = lvl_reg + 1'b1;
        else if (do_pop && !do_push) lvl_next = lvl_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) entries_reg[wr_ptr_reg] <= wr_req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lvl_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            lvl_reg    <= lvl_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/urlpd_back.sv
// Back end: walks the head request onto the result port, one result per cycle while m_ready is high.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_back import urlpd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire req_t head,
    input  wire logic head_valid,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic [7:0] m_out_byte,
    output logic      m_out_term,
    output logic      m_run_last
);

    logic [RES_CNT_W-1:0] idx_reg, idx_next;
    logic                 last, take;

    assign m_valid = head_valid;
    assign last    = (idx_reg + 1'b1) == head.n;
    assign take    = m_valid && m_ready;
    assign pop     = take && last;

    always_comb begin
        case (idx_reg)
            RES_CNT_W'(0): m_out_byte = head.bytes[0];
            RES_CNT_W'(1): m_out_byte = head.bytes[1];
            default:       m_out_byte = head.bytes[2];
        endcase
    end

    assign m_out_term = head.term && last;
    assign m_run_last = last;

    always_comb begin
        idx_next = idx_reg;
        if (take) idx_next = last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/url_percent_decoder.sv
// Channel   Direction  Ports
// source    in         s_valid s_ready s_src_byte[7:0] s_src_end
// result    out        m_valid m_ready m_out_byte[7:0] m_out_term m_run_last
// config    in         cfg_we cfg_wdata[7:0]  (max output length, reset 63)
//
// A source item is taken every cycle while the 4-entry request queue has room;
// the front end decodes it in the cycle it is taken.
// The back end gives one result per cycle while m_ready is high; an item yields
// up to three results, and items with no result are not queued.
// Reset is synchronous, active low; limit returns to 63, queue empties.
// Result stalls back up through the queue to s_ready only once it is full.
// Top level of the URL percent decoder; depends on urlpd_pkg, urlpd_front,
// urlpd_queue and urlpd_back.
`default_nettype none

module url_percent_decoder import urlpd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_src_byte,
    input  wire logic       s_src_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_term,
    output logic            m_run_last
);

    req_t   wr_req, rd_req;
    qstat_t q_stat;
    logic   push, pop, accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    urlpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .src_byte  (s_src_byte),
        .src_end   (s_src_end),
        .req       (wr_req),
        .push      (push)
    );

    urlpd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_req  (wr_req),
        .pop     (pop),
        .rd_req  (rd_req),
        .stat    (q_stat)
    );

    urlpd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (rd_req),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_term (m_out_term),
        .m_run_last (m_run_last)
    );

    // Terminator is always a zero byte and closes its request
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_term |-> (m_out_byte == CHAR_NUL) && m_run_last)
        else $error("terminator not zero or not last");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.level <= QLVL_W'(QDEPTH))
        else $error("queue level overflow");

    a_level_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && !q_stat.full |=> q_stat.level == $past(q_stat.level) + 1'b1)
        else $error("queue level did not track push");

    a_no_empty_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> rd_req.n != '0)
        else $error("empty request at queue head");

endmodule

`default_nettype wire
